// ===== sv/windowed_nearest_waypoint_search_assert.svh =====
// Assertion macros shared by the waypoint search modules.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef WINDOWED_NEAREST_WAYPOINT_SEARCH_ASSERT_SVH
`define WINDOWED_NEAREST_WAYPOINT_SEARCH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WNS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WNS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wns_pkg.sv =====
// Shared constants, codes and types for the windowed nearest waypoint search.
// No dependencies; every module file imports this package.
package wns_pkg;

  localparam int MAX_POINTS    = 1024;
  localparam int NUM_PATHS     = 4;
  localparam int WINDOW_BEHIND = 3;
  localparam int WINDOW_LENGTH = 10;

  localparam int CMD_W     = 2;
  localparam int PATH_W    = $clog2(NUM_PATHS);
  localparam int PIDX_W    = $clog2(MAX_POINTS);
  localparam int CNT_W     = PIDX_W + 1;
  localparam int ADDR_W    = PATH_W + PIDX_W;
  localparam int MEM_DEPTH = NUM_PATHS * MAX_POINTS;
  localparam int BIT_W     = $clog2(PIDX_W);
  localparam int WB_W      = $clog2(WINDOW_BEHIND + 1) + 1;

  localparam int POS_W   = 20;
  localparam int FRAC_W  = 4;
  localparam int COORD_W = 16;
  localparam int TAG_W   = 16;
  localparam int AXES    = 3;
  localparam int WORD_W  = COORD_W * AXES + TAG_W;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 2 * POS_W + 1;
  localparam int DIST_W  = SQ_W + 1;
  localparam int RAD_W   = 44;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RAD_W;

  localparam logic [RAD_W-1:0] RAD_TAGGED_RESET   = 44'd64000000;
  localparam logic [RAD_W-1:0] RAD_UNTAGGED_RESET = 44'd40960000;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE    = 2'd0,
    CMD_TAGGED   = 2'd1,
    CMD_UNTAGGED = 2'd2,
    CMD_SCAN     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNT0       = 3'd0,
    REG_COUNT1       = 3'd1,
    REG_COUNT2       = 3'd2,
    REG_COUNT3       = 3'd3,
    REG_RAD_TAGGED   = 3'd4,
    REG_RAD_UNTAGGED = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_BACK,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  // Tracks one candidate point through the distance unit.
  typedef struct packed {
    logic [PIDX_W-1:0] idx;
    logic              tag_ok;
    logic              last;
  } meta_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } query_t;

endpackage

// ===== sv/windowed_nearest_waypoint_search.sv =====
// Windowed nearest waypoint search. Write points with cmd 0 (accepted back to back,
// no result); cmd 1 and 2 search ten points around a centre index (tag-filtered or
// not, against the radius registers) and cmd 3 scans the whole path, each giving
// one result transaction. Configure counts and radii only while idle. When the
// centre index is at or beyond the path count, a bit-serial remainder finds the
// window start first. Search time is set by the single squarer, which handles one
// axis per cycle, one stored point after another. A new transaction is accepted
// while a finished result still waits in the output register.
module windowed_nearest_waypoint_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wns_pkg::CMD_W-1:0]           in_cmd,
  input  logic [wns_pkg::PATH_W-1:0]          in_path_select,
  input  logic [wns_pkg::PIDX_W-1:0]          in_point_index,
  input  logic signed [wns_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [wns_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [wns_pkg::POS_W-1:0]    in_pos_z,
  input  logic [wns_pkg::TAG_W-1:0]           in_section_id,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [wns_pkg::PIDX_W-1:0]          out_nearest_index,
  input  logic                                cfg_we,
  input  logic [wns_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wns_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import wns_pkg::*;

  logic [CNT_W-1:0]  count_r [NUM_PATHS];
  logic [RAD_W-1:0]  rad_tagged_r;
  logic [RAD_W-1:0]  rad_untagged_r;
  logic [CNT_W-1:0]  count_raw;
  logic [CNT_W-1:0]  count_sel;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;
  query_t            query;
  logic              dist_start;
  logic [WORD_W-1:0] dist_word;
  meta_t             dist_meta_in;
  logic              dist_valid;
  logic [DIST_W-1:0] dist_value;
  meta_t             dist_meta_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PATHS; i++) begin
        count_r[i] <= CNT_W'(1);
      end
      rad_tagged_r   <= RAD_TAGGED_RESET;
      rad_untagged_r <= RAD_UNTAGGED_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COUNT0:       count_r[0]     <= cfg_wdata[CNT_W-1:0];
        REG_COUNT1:       count_r[1]     <= cfg_wdata[CNT_W-1:0];
        REG_COUNT2:       count_r[2]     <= cfg_wdata[CNT_W-1:0];
        REG_COUNT3:       count_r[3]     <= cfg_wdata[CNT_W-1:0];
        REG_RAD_TAGGED:   rad_tagged_r   <= cfg_wdata[RAD_W-1:0];
        REG_RAD_UNTAGGED: rad_untagged_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the selected path count into 1..MAX_POINTS.
  always_comb begin
    count_raw = count_r[in_path_select];
    if (count_raw == '0) begin
      count_sel = CNT_W'(1);
    end else if (count_raw > CNT_W'(MAX_POINTS)) begin
      count_sel = CNT_W'(MAX_POINTS);
    end else begin
      count_sel = count_raw;
    end
  end

  wns_point_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  wns_dist_unit u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (dist_start),
    .word       (dist_word),
    .meta_in    (dist_meta_in),
    .query      (query),
    .dist_valid (dist_valid),
    .dist_sum   (dist_value),
    .meta_out   (dist_meta_out)
  );

  wns_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_path_select    (in_path_select),
    .in_point_index    (in_point_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_section_id     (in_section_id),
    .count_sel         (count_sel),
    .rad_tagged        (rad_tagged_r),
    .rad_untagged      (rad_untagged_r),
    .mem_req           (mem_req),
    .mem_rdata         (mem_rdata),
    .query             (query),
    .dist_start        (dist_start),
    .dist_word         (dist_word),
    .dist_meta_in      (dist_meta_in),
    .dist_valid        (dist_valid),
    .dist_value        (dist_value),
    .dist_meta_out     (dist_meta_out),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index)
  );

endmodule

// ===== sv/wns_point_mem.sv =====
// Waypoint storage: one write-or-read port, registered read data.
// Depends on wns_pkg for depth, word width and the request struct.
module wns_point_mem (
  input  logic                        clk,
  input  wns_pkg::mem_req_t           req,
  output logic [wns_pkg::WORD_W-1:0]  rdata
);
  import wns_pkg::*;

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/wns_dist_unit.sv =====
// Shared squared-distance unit: one squarer, one axis per cycle, then accumulate.
// Depends on wns_pkg and the assertion macro header.
module wns_dist_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wns_pkg::WORD_W-1:0]  word,
  input  wns_pkg::meta_t              meta_in,
  input  wns_pkg::query_t             query,
  output logic                        dist_valid,
  output logic [wns_pkg::DIST_W-1:0]  dist_sum,
  output wns_pkg::meta_t              meta_out
);
  import wns_pkg::*;
  `include "windowed_nearest_waypoint_search_assert.svh"

  logic [COORD_W*AXES-1:0] coord_r, coord_nxt;
  meta_t                   meta_r, meta_nxt;
  logic                    busy_r, busy_nxt;
  axis_t                   axis_r, axis_nxt;

  logic [SQ_W-1:0]         prod_r, prod_nxt;
  meta_t                   pmeta_r, pmeta_nxt;
  logic                    pv_r, pv_nxt;
  logic                    pfirst_r, pfirst_nxt;
  logic                    plast_r, plast_nxt;

  logic [DIST_W-1:0]       acc_r, acc_nxt;
  meta_t                   ometa_r, ometa_nxt;
  logic                    ov_r, ov_nxt;

  logic [COORD_W-1:0]      c_sel;
  logic signed [POS_W-1:0] q_sel;
  logic signed [DIFF_W-1:0] pt_s, q_s, diff;
  logic signed [2*DIFF_W-1:0] sq;

  always_comb begin
    case (axis_r)
      AX_X: begin
        c_sel = coord_r[COORD_W-1:0];
        q_sel = query.x;
      end
      AX_Y: begin
        c_sel = coord_r[2*COORD_W-1:COORD_W];
        q_sel = query.y;
      end
      default: begin
        c_sel = coord_r[3*COORD_W-1:2*COORD_W];
        q_sel = query.z;
      end
    endcase
    // Stored coordinates are whole units; scale to Q.4 before subtracting.
    pt_s = signed'({c_sel[COORD_W-1], c_sel, {FRAC_W{1'b0}}});
    q_s  = signed'({q_sel[POS_W-1], q_sel});
    diff = pt_s - q_s;
    sq   = diff * diff;
  end

  always_comb begin
    coord_nxt  = coord_r;
    meta_nxt   = meta_r;
    busy_nxt   = busy_r;
    axis_nxt   = axis_r;
    if (busy_r) begin
      case (axis_r)
        AX_X:    axis_nxt = AX_Y;
        AX_Y:    axis_nxt = AX_Z;
        default: begin
          axis_nxt = AX_X;
          busy_nxt = 1'b0;
        end
      endcase
    end
    // A new point may load on the cycle the last axis is squared.
    if (start) begin
      coord_nxt = word[COORD_W*AXES-1:0];
      meta_nxt  = meta_in;
      busy_nxt  = 1'b1;
      axis_nxt  = AX_X;
    end

    pv_nxt     = busy_r;
    prod_nxt   = sq[SQ_W-1:0];
    pfirst_nxt = (axis_r == AX_X);
    plast_nxt  = (axis_r == AX_Z);
    pmeta_nxt  = meta_r;

    acc_nxt   = acc_r;
    ometa_nxt = ometa_r;
    if (pv_r) begin
      acc_nxt = (pfirst_r ? '0 : acc_r) + DIST_W'(prod_r);
      if (plast_r) begin
        ometa_nxt = pmeta_r;
      end
    end
    ov_nxt = pv_r && plast_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      axis_r <= AX_X;
      pv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      axis_r <= axis_nxt;
      pv_r   <= pv_nxt;
      ov_r   <= ov_nxt;
    end
    coord_r  <= coord_nxt;
    meta_r   <= meta_nxt;
    prod_r   <= prod_nxt;
    pmeta_r  <= pmeta_nxt;
    pfirst_r <= pfirst_nxt;
    plast_r  <= plast_nxt;
    acc_r    <= acc_nxt;
    ometa_r  <= ometa_nxt;
  end

  assign dist_valid = ov_r;
  assign dist_sum   = acc_r;
  assign meta_out   = ometa_r;

  `WNS_ASSERT_IMP(a_start_when_free, start, !busy_r || axis_r == AX_Z, "point loaded mid-sweep")
  `WNS_ASSERT_NXT(a_dist_single, dist_valid, !dist_valid, "distance results back to back")
  `WNS_ASSERT_IMP(a_prod_from_busy, pv_r, $past(busy_r), "product without squarer activity")

endmodule

// ===== sv/wns_ctrl.sv =====
// Search sequencer: command decode, remainder unit for the window start,
// point fetch, best-candidate tracking and the result register.
// Depends on wns_pkg and the assertion macro header.
module wns_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wns_pkg::CMD_W-1:0]         in_cmd,
  input  logic [wns_pkg::PATH_W-1:0]        in_path_select,
  input  logic [wns_pkg::PIDX_W-1:0]        in_point_index,
  input  logic signed [wns_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [wns_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [wns_pkg::POS_W-1:0]  in_pos_z,
  input  logic [wns_pkg::TAG_W-1:0]         in_section_id,
  input  logic [wns_pkg::CNT_W-1:0]         count_sel,
  input  logic [wns_pkg::RAD_W-1:0]         rad_tagged,
  input  logic [wns_pkg::RAD_W-1:0]         rad_untagged,
  output wns_pkg::mem_req_t                 mem_req,
  input  logic [wns_pkg::WORD_W-1:0]        mem_rdata,
  output wns_pkg::query_t                   query,
  output logic                              dist_start,
  output logic [wns_pkg::WORD_W-1:0]        dist_word,
  output wns_pkg::meta_t                    dist_meta_in,
  input  logic                              dist_valid,
  input  logic [wns_pkg::DIST_W-1:0]        dist_value,
  input  wns_pkg::meta_t                    dist_meta_out,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [wns_pkg::PIDX_W-1:0]        out_nearest_index
);
  import wns_pkg::*;
  `include "windowed_nearest_waypoint_search_assert.svh"

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [PATH_W-1:0]  path_r, path_nxt;
  query_t             q_r, q_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [RAD_W-1:0]   best_r, best_nxt;
  logic               have_r, have_nxt;
  logic               found_r, found_nxt;
  logic [PIDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [PIDX_W-1:0]  pidx_r, pidx_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [WB_W-1:0]    back_r, back_nxt;
  logic [PIDX_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]   steps_r, steps_nxt;
  axis_t              phase_r, phase_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [PIDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [PIDX_W-1:0]  out_index_r, out_index_nxt;

  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   rem_sh;
  logic               take;

  assign cnt_m1 = count_r - CNT_W'(1);
  assign rem_sh = {rem_r[PIDX_W-1:0], pidx_r[PIDX_W-1]};

  // Tag test happens as the word leaves the memory.
  assign dist_start          = rd_pend_r;
  assign dist_word           = mem_rdata;
  assign dist_meta_in.idx    = rd_idx_r;
  assign dist_meta_in.last   = rd_last_r;
  assign dist_meta_in.tag_ok = (cmd_r != CMD_TAGGED) ||
                               (mem_rdata[WORD_W-1 -: TAG_W] == tag_r);
  assign query = q_r;

  // Strict compare keeps the earlier point on a tie.
  assign take = dist_valid && dist_meta_out.tag_ok &&
                (!have_r || (RAD_W'(dist_value) < best_r));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    path_nxt      = path_r;
    q_nxt         = q_r;
    tag_nxt       = tag_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    have_nxt      = have_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    rem_nxt       = rem_r;
    pidx_nxt      = pidx_r;
    bit_nxt       = bit_r;
    back_nxt      = back_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    phase_nxt     = phase_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    rd_last_nxt   = rd_last_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;

    in_stall      = (state_r != ST_IDLE);
    mem_req.we    = 1'b0;
    mem_req.addr  = {path_r, cur_r};
    mem_req.wdata = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (take) begin
      best_nxt     = RAD_W'(dist_value);
      best_idx_nxt = dist_meta_out.idx;
      have_nxt     = 1'b1;
      found_nxt    = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd_t'(in_cmd) == CMD_WRITE) begin
            // Drop the fraction bits: points are stored in whole units.
            mem_req.we    = 1'b1;
            mem_req.addr  = {in_path_select, in_point_index};
            mem_req.wdata = {in_section_id, in_pos_z[POS_W-1:FRAC_W],
                             in_pos_y[POS_W-1:FRAC_W], in_pos_x[POS_W-1:FRAC_W]};
          end else begin
            cmd_nxt      = cmd_t'(in_cmd);
            path_nxt     = in_path_select;
            q_nxt.x      = in_pos_x;
            q_nxt.y      = in_pos_y;
            q_nxt.z      = in_pos_z;
            tag_nxt      = in_section_id;
            count_nxt    = count_sel;
            found_nxt    = 1'b0;
            best_idx_nxt = '0;
            phase_nxt    = AX_X;
            if (cmd_t'(in_cmd) == CMD_SCAN) begin
              have_nxt  = 1'b0;
              best_nxt  = '0;
              cur_nxt   = '0;
              steps_nxt = count_sel;
              state_nxt = ST_ISSUE;
            end else begin
              have_nxt  = 1'b1;
              best_nxt  = (cmd_t'(in_cmd) == CMD_TAGGED) ? rad_tagged : rad_untagged;
              steps_nxt = CNT_W'(WINDOW_LENGTH);
              back_nxt  = WB_W'(WINDOW_BEHIND);
              if (CNT_W'(in_point_index) < count_sel) begin
                cur_nxt   = in_point_index;
                state_nxt = ST_BACK;
              end else begin
                rem_nxt   = '0;
                pidx_nxt  = in_point_index;
                bit_nxt   = BIT_W'(PIDX_W - 1);
                state_nxt = ST_MOD;
              end
            end
          end
        end
      end

      ST_MOD: begin
        // Restoring remainder, one centre-index bit per cycle.
        rem_nxt  = (rem_sh >= count_r) ? (rem_sh - count_r) : rem_sh;
        pidx_nxt = pidx_r << 1;
        if (bit_r == '0) begin
          cur_nxt   = rem_nxt[PIDX_W-1:0];
          state_nxt = ST_BACK;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end

      ST_BACK: begin
        // Step back to the window start, wrapping below zero.
        if (back_r == '0) begin
          phase_nxt = AX_X;
          state_nxt = ST_ISSUE;
        end else begin
          cur_nxt  = (cur_r == '0) ? cnt_m1[PIDX_W-1:0] : cur_r - PIDX_W'(1);
          back_nxt = back_r - WB_W'(1);
        end
      end

      ST_ISSUE: begin
        // One fetch per pass through the X, Y, Z phases keeps the squarer busy every cycle.
        case (phase_r)
          AX_X: begin
            rd_pend_nxt = 1'b1;
            rd_idx_nxt  = cur_r;
            rd_last_nxt = (steps_r == CNT_W'(1));
            cur_nxt     = (CNT_W'(cur_r) == cnt_m1) ? '0 : cur_r + PIDX_W'(1);
            steps_nxt   = steps_r - CNT_W'(1);
            phase_nxt   = AX_Y;
            if (steps_r == CNT_W'(1)) begin
              state_nxt = ST_DRAIN;
            end
          end
          AX_Y:    phase_nxt = AX_Z;
          default: phase_nxt = AX_X;
        endcase
      end

      ST_DRAIN: begin
        if (dist_valid && dist_meta_out.last) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Hold until the result register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_index_nxt = found_r ? best_idx_r : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= AX_X;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
    cmd_r       <= cmd_nxt;
    path_r      <= path_nxt;
    q_r         <= q_nxt;
    tag_r       <= tag_nxt;
    count_r     <= count_nxt;
    best_r      <= best_nxt;
    have_r      <= have_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    rem_r       <= rem_nxt;
    pidx_r      <= pidx_nxt;
    bit_r       <= bit_nxt;
    back_r      <= back_nxt;
    cur_r       <= cur_nxt;
    steps_r     <= steps_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_last_r   <= rd_last_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_nearest_index = out_index_r;

  `WNS_ASSERT_IMP(a_idle_quiet, state_r == ST_IDLE, !dist_valid && !rd_pend_r, "fetch in flight while idle")
  `WNS_ASSERT_IMP(a_cur_in_path, state_r == ST_ISSUE, CNT_W'(cur_r) < count_r, "fetch index past path end")
  `WNS_ASSERT_IMP(a_issue_left, state_r == ST_ISSUE, steps_r != '0, "fetch state with no points left")
  `WNS_ASSERT_IMP(a_scan_found, state_r == ST_FINISH && cmd_r == CMD_SCAN, found_r, "full scan without a result")

endmodule

// ===== tb/tb_windowed_nearest_waypoint_search.sv =====
// Self-checking testbench for windowed_nearest_waypoint_search: directed rows, then random
// phases with random input gaps and output stalls, checked against an in-bench nearest-point model.
// Depends on wns_pkg and the RTL of windowed_nearest_waypoint_search only.
module tb_windowed_nearest_waypoint_search;
  import wns_pkg::*;

  localparam int CYCLE_LIMIT     = 2000000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int RAND_PHASES     = 16;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int COUNT_REG_MAX   = (1 << CNT_W) - 1;
  localparam bit PRED            = 1'b0;
  localparam bit TYPED           = 1'b1;

  localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;
  localparam logic [TAG_W-1:0]        TAG_ALL = 16'hFFFF;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [TAG_W-1:0]   tag;
  } waypoint_t;

  typedef struct packed {
    logic              found;
    logic [PIDX_W-1:0] idx;
  } nearest_t;

  typedef struct {
    cmd_t                    cmd;
    logic [PATH_W-1:0]       path;
    logic [PIDX_W-1:0]       pidx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [TAG_W-1:0]        tag;
    bit                      typed;
    logic                    exp_found;
    logic [PIDX_W-1:0]       exp_idx;
  } txn_t;

  typedef struct {
    bit                   is_cfg;
    cfg_reg_t             cfg_sel;
    logic [RAD_W-1:0]     cfg_val;
    txn_t                 t;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_cmd = '0;
  logic [PATH_W-1:0]       in_path_select = '0;
  logic [PIDX_W-1:0]       in_point_index = '0;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic signed [POS_W-1:0] in_pos_z = '0;
  logic [TAG_W-1:0]        in_section_id = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_found;
  logic [PIDX_W-1:0]       out_nearest_index;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // Model state: point memory, which entries hold data, and the register copies.
  waypoint_t        waypoints [NUM_PATHS][MAX_POINTS];
  bit               written [NUM_PATHS][MAX_POINTS];
  logic [CNT_W-1:0] path_count [NUM_PATHS];
  logic [RAD_W-1:0] radius_tagged = RAD_TAGGED_RESET;
  logic [RAD_W-1:0] radius_untagged = RAD_UNTAGGED_RESET;

  nearest_t nearest_q [$];
  dir_row_t dir_rows [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       stall_left = 0;
  bit       idle_on = 1'b1;
  bit       stall_on = 1'b1;

  windowed_nearest_waypoint_search u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_path_select    (in_path_select),
    .in_point_index    (in_point_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_section_id     (in_section_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_windowed_nearest_waypoint_search failed");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int burst_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_count(logic [PATH_W-1:0] p);
    int c;
    c = int'(path_count[p]);
    if (c < 1) c = 1;
    if (c > MAX_POINTS) c = MAX_POINTS;
    return c;
  endfunction

  function automatic int win_idx(logic [PIDX_W-1:0] centre, int k, int cnt);
    int v;
    v = (int'(centre) + k - WINDOW_BEHIND) % cnt;
    if (v < 0) v += cnt;
    return v;
  endfunction

  function automatic longint dist_sq(waypoint_t w, txn_t t);
    longint dx, dy, dz;
    dx = longint'($signed(w.x)) * 16 - longint'($signed(t.x));
    dy = longint'($signed(w.y)) * 16 - longint'($signed(t.y));
    dz = longint'($signed(w.z)) * 16 - longint'($signed(t.z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic nearest_t predict_nearest(txn_t t);
    nearest_t r;
    longint   best, d;
    int       cnt, v;
    r.found = 1'b0;
    r.idx = '0;
    cnt = eff_count(t.path);
    if (t.cmd == CMD_SCAN) begin
      r.found = 1'b1;
      best = dist_sq(waypoints[t.path][0], t);
      for (int i = 1; i < cnt; i++) begin
        d = dist_sq(waypoints[t.path][i], t);
        if (d < best) begin
          best = d;
          r.idx = PIDX_W'(i);
        end
      end
    end else begin
      best = (t.cmd == CMD_TAGGED) ? longint'(radius_tagged) : longint'(radius_untagged);
      for (int k = 0; k < WINDOW_LENGTH; k++) begin
        v = win_idx(t.pidx, k, cnt);
        if (t.cmd != CMD_TAGGED || waypoints[t.path][v].tag == t.tag) begin
          d = dist_sq(waypoints[t.path][v], t);
          if (d < best) begin
            best = d;
            r.idx = PIDX_W'(v);
            r.found = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_coord();
    if ($urandom_range(0, 3) != 0)
      return POS_W'($urandom_range(0, 400) * 16 - 3200 + $urandom_range(0, 15));
    return POS_W'($urandom());
  endfunction

  function automatic txn_t make_write(logic [PATH_W-1:0] p, int slot);
    txn_t t;
    int   pick;
    t.cmd = CMD_WRITE;
    t.path = p;
    t.pidx = PIDX_W'(slot);
    t.typed = PRED;
    t.x = rand_coord();
    t.y = rand_coord();
    t.z = rand_coord();
    pick = $urandom_range(0, 99);
    if (pick < 70) t.tag = TAG_W'($urandom_range(0, 3));
    else if (pick < 90) t.tag = TAG_W'($urandom());
    else t.tag = TAG_ALL;
    return t;
  endfunction

  function automatic dir_row_t op_row(cmd_t c, logic [PATH_W-1:0] p, logic [PIDX_W-1:0] idx,
      logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
      logic [TAG_W-1:0] tag, bit typed, logic f, logic [PIDX_W-1:0] ei);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.t.cmd = c;
    r.t.path = p;
    r.t.pidx = idx;
    r.t.x = x;
    r.t.y = y;
    r.t.z = z;
    r.t.tag = tag;
    r.t.typed = typed;
    r.t.exp_found = f;
    r.t.exp_idx = ei;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_reg_t sel, logic [RAD_W-1:0] val);
    dir_row_t r;
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return RAD_W'($urandom_range(0, 5000));
      3: return RAD_W'($urandom_range(0, 200000));
      4: return RAD_TAGGED_RESET;
      5: return RAD_UNTAGGED_RESET;
      default: return RAD_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 24);
    if (r < 80) return $urandom_range(25, 300);
    if (r < 87) return 0;
    if (r < 94) return MAX_POINTS;
    return COUNT_REG_MAX;
  endfunction

  // Send one transaction; entered and left at a falling edge.
  task automatic push_txn(txn_t t);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 40) ? burst_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= t.cmd;
    in_path_select <= t.path;
    in_point_index <= t.pidx;
    in_pos_x <= t.x;
    in_pos_y <= t.y;
    in_pos_z <= t.z;
    in_section_id <= t.tag;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (t.cmd == CMD_WRITE) begin
      waypoints[t.path][t.pidx] = {t.x[POS_W-1:FRAC_W], t.y[POS_W-1:FRAC_W],
                                   t.z[POS_W-1:FRAC_W], t.tag};
      written[t.path][t.pidx] = 1'b1;
    end else if (t.typed) begin
      nearest_q.push_back({t.exp_found, t.exp_idx});
    end else begin
      nearest_q.push_back(predict_nearest(t));
    end
    @(negedge clk);
  endtask

  // Write random points into every entry the search will read that holds no data yet.
  task automatic fill_reads(logic [PATH_W-1:0] p, cmd_t c, logic [PIDX_W-1:0] centre);
    int cnt, n;
    cnt = eff_count(p);
    n = (c == CMD_SCAN) ? cnt : WINDOW_LENGTH;
    for (int k = 0; k < n; k++) begin
      int v;
      v = (c == CMD_SCAN) ? k : win_idx(centre, k, cnt);
      if (!written[p][v]) push_txn(make_write(p, v));
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write.
  task automatic cfg_write(cfg_reg_t sel, logic [RAD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    case (sel)
      REG_RAD_TAGGED:   radius_tagged = val;
      REG_RAD_UNTAGGED: radius_untagged = val;
      default:          path_count[int'(sel)] = val[CNT_W-1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic send_random();
    txn_t      t;
    waypoint_t anchor;
    int        cnt, pick, slot;
    t.path = PATH_W'($urandom_range(0, NUM_PATHS - 1));
    cnt = eff_count(t.path);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      if ($urandom_range(0, 3) != 0) slot = $urandom_range(0, cnt + 2) % MAX_POINTS;
      else slot = $urandom_range(0, MAX_POINTS - 1);
      t = make_write(t.path, slot);
    end else begin
      t.typed = PRED;
      if (pick < 55) t.cmd = CMD_TAGGED;
      else if (pick < 80) t.cmd = CMD_UNTAGGED;
      else t.cmd = CMD_SCAN;
      // keep full scans of long paths rare
      if (t.cmd == CMD_SCAN && cnt > 64 && $urandom_range(0, 3) != 0) t.cmd = CMD_UNTAGGED;
      if ($urandom_range(0, 1) != 0) t.pidx = PIDX_W'($urandom_range(0, cnt - 1));
      else t.pidx = PIDX_W'($urandom());
      fill_reads(t.path, t.cmd, t.pidx);
      if (t.cmd == CMD_SCAN) slot = $urandom_range(0, cnt - 1);
      else slot = win_idx(t.pidx, $urandom_range(0, WINDOW_LENGTH - 1), cnt);
      anchor = waypoints[t.path][slot];
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // aim close to a point the search will see
        t.x = POS_W'({anchor.x, {FRAC_W{1'b0}}} + $urandom_range(0, 128) - 64);
        t.y = POS_W'({anchor.y, {FRAC_W{1'b0}}} + $urandom_range(0, 128) - 64);
        t.z = POS_W'({anchor.z, {FRAC_W{1'b0}}} + $urandom_range(0, 128) - 64);
      end else if (pick < 85) begin
        t.x = POS_W'($urandom_range(0, 6400) - 3200);
        t.y = POS_W'($urandom_range(0, 6400) - 3200);
        t.z = POS_W'($urandom_range(0, 6400) - 3200);
      end else begin
        t.x = POS_W'($urandom());
        t.y = POS_W'($urandom());
        t.z = POS_W'($urandom());
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) t.tag = anchor.tag;
      else if (pick < 85) t.tag = TAG_W'($urandom_range(0, 3));
      else t.tag = TAG_W'($urandom());
    end
    push_txn(t);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 99) < 30) begin
      stall_left = burst_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    nearest_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (nearest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0b index=%0d", out_found, out_nearest_index);
      end else begin
        want = nearest_q.pop_front();
        if (out_found !== want.found || out_nearest_index !== want.idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                     want.found, want.idx, out_found, out_nearest_index);
        end
      end
    end
  end

  initial begin
    foreach (path_count[p]) path_count[p] = CNT_W'(1);

    // All counts are 1 after reset, so every window folds onto point 0.
    // The fraction bits of x are dropped on write.
    dir_rows.push_back(op_row(CMD_WRITE, 2'd0, 10'd0, 20'sd1615, -20'sd800, 20'sd112,
                              16'h0001, PRED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_SCAN, 2'd0, 10'd0, 20'sd0, 20'sd0, 20'sd0,
                              16'h0000, TYPED, 1'b1, 10'd0));
    dir_rows.push_back(op_row(CMD_TAGGED, 2'd0, 10'd0, 20'sd1600, -20'sd800, 20'sd112,
                              16'h0001, TYPED, 1'b1, 10'd0));
    dir_rows.push_back(op_row(CMD_TAGGED, 2'd0, 10'd0, 20'sd1600, -20'sd800, 20'sd112,
                              16'h0002, TYPED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_UNTAGGED, 2'd0, 10'd1023, POS_MIN, POS_MIN, POS_MIN,
                              16'h0000, TYPED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_UNTAGGED, 2'd0, 10'd512, 20'sd1615, -20'sd800, 20'sd112,
                              16'h0000, TYPED, 1'b1, 10'd0));
    // Coordinate extremes, and a write far past the path count.
    dir_rows.push_back(op_row(CMD_WRITE, 2'd3, 10'd1023, POS_MAX, POS_MIN, 20'sd0,
                              TAG_ALL, PRED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_WRITE, 2'd3, 10'd0, POS_MIN, POS_MAX, -20'sd16,
                              TAG_ALL, PRED, 1'b0, 10'd0));
    // A count of zero behaves as one.
    dir_rows.push_back(cfg_row(REG_COUNT3, '0));
    dir_rows.push_back(op_row(CMD_SCAN, 2'd3, 10'd0, POS_MAX, POS_MAX, POS_MAX,
                              TAG_ALL, TYPED, 1'b1, 10'd0));
    // Count above the memory size is clipped; the window wraps back over index 1023.
    dir_rows.push_back(cfg_row(REG_COUNT3, RAD_W'(COUNT_REG_MAX)));
    dir_rows.push_back(op_row(CMD_TAGGED, 2'd3, 10'd0, POS_MAX, POS_MIN, 20'sd0,
                              TAG_ALL, PRED, 1'b0, 10'd0));
    dir_rows.push_back(cfg_row(REG_RAD_TAGGED, '0));
    dir_rows.push_back(op_row(CMD_TAGGED, 2'd0, 10'd0, 20'sd1600, -20'sd800, 20'sd112,
                              16'h0001, TYPED, 1'b0, 10'd0));
    dir_rows.push_back(cfg_row(REG_RAD_UNTAGGED, '1));
    dir_rows.push_back(op_row(CMD_UNTAGGED, 2'd0, 10'd7, POS_MIN, POS_MAX, POS_MIN,
                              16'h0000, TYPED, 1'b1, 10'd0));
    dir_rows.push_back(cfg_row(REG_COUNT1, RAD_W'(MAX_POINTS)));
    dir_rows.push_back(cfg_row(REG_COUNT2, RAD_W'(16)));
    // Two equal points: the earlier index wins the tie.
    dir_rows.push_back(op_row(CMD_WRITE, 2'd2, 10'd3, 20'sd2560, 20'sd2560, -20'sd2560,
                              16'h0005, PRED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_WRITE, 2'd2, 10'd5, 20'sd2560, 20'sd2560, -20'sd2560,
                              16'h0005, PRED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_UNTAGGED, 2'd2, 10'd4, 20'sd2560, 20'sd2560, -20'sd2560,
                              16'h0000, PRED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_SCAN, 2'd2, 10'd0, 20'sd2565, 20'sd2560, -20'sd2555,
                              16'h0000, PRED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_TAGGED, 2'd1, 10'd1023, 20'sd0, 20'sd0, 20'sd0,
                              TAG_ALL, PRED, 1'b0, 10'd0));
    dir_rows.push_back(op_row(CMD_UNTAGGED, 2'd1, 10'd0, POS_MAX, 20'sd0, POS_MIN,
                              16'h0000, PRED, 1'b0, 10'd0));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        quiesce();
        cfg_write(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
        cfg_we <= 1'b0;
      end else begin
        if (dir_rows[i].t.cmd != CMD_WRITE)
          fill_reads(dir_rows[i].t.path, dir_rows[i].t.cmd, dir_rows[i].t.pidx);
        push_txn(dir_rows[i].t);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiesce();
      idle_on = ($urandom_range(0, 4) != 0);
      stall_on = ($urandom_range(0, 4) != 0);
      for (int p = 0; p < NUM_PATHS; p++)
        cfg_write(cfg_reg_t'(REG_COUNT0 + p), RAD_W'(pick_count()));
      cfg_write(REG_RAD_TAGGED, pick_radius());
      cfg_write(REG_RAD_UNTAGGED, pick_radius());
      cfg_we <= 1'b0;
      repeat (ITEMS_PER_PHASE) send_random();
    end

    quiesce();
    if (mismatches == 0) begin
      $display("tb_windowed_nearest_waypoint_search passed");
    end else begin
      $display("tb_windowed_nearest_waypoint_search failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/wns_pkg.sv
sv/wns_point_mem.sv
sv/wns_dist_unit.sv
sv/wns_ctrl.sv
sv/windowed_nearest_waypoint_search.sv
tb/tb_windowed_nearest_waypoint_search.sv
